@@ hdl/tskd_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tskd_pkg
// Shared constants, types and tables for the keyword-tracking token scanner.
// ---------------------------------------------------------------------------
package tskd_pkg;

  // Longest token length reported; lengths saturate here.
  localparam int MAX_TOKEN_LEN = 255;
  localparam int LEN_CAP       = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;

  // Scan modes.
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_NUM  = 2'd1;
  localparam logic [1:0] MODE_WORD = 2'd2;
  localparam logic [1:0] MODE_HALT = 2'd3;

  // Automaton markers.
  localparam logic [3:0] KW_START = 4'd0;
  localparam logic [3:0] KW_NONE  = 4'd0;
  localparam logic [3:0] KW_DEAD  = 4'd14;
  localparam logic [3:0] KW_ACC   = 4'd15;
  localparam int         KW_STATES = 14;
  localparam int         KW_COLS   = 12;

  // Character classes.
  localparam logic [2:0] CLS_OTHER = 3'd0;
  localparam logic [2:0] CLS_WS    = 3'd1;
  localparam logic [2:0] CLS_SYM   = 3'd2;
  localparam logic [2:0] CLS_ALPHA = 3'd3;
  localparam logic [2:0] CLS_DIGIT = 3'd4;

  // Token kinds.
  localparam logic [2:0] KIND_NUM = 3'd0;
  localparam logic [2:0] KIND_ID  = 3'd1;
  localparam logic [2:0] KIND_KW  = 3'd2;
  localparam logic [2:0] KIND_SYM = 3'd3;
  localparam logic [2:0] KIND_WS  = 3'd4;
  localparam logic [2:0] KIND_ERR = 3'd5;

  // Keyword codes.
  localparam logic [2:0] KWC_NONE = 3'd0;

  // One result word.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] len;
    logic [2:0] kw;
    logic       last;
  } result_t;

  // Next automaton state per state and letter column; KW_ACC marks a completing letter.
  localparam logic [3:0] KW_NEXT [KW_STATES][KW_COLS] = '{
    '{4'd0, 4'd0, 4'd1,  4'd0,  4'd0,  4'd5, 4'd0, 4'd0,  4'd6,  4'd0, 4'd11, 4'd0},
    '{4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd2, 4'd4,  4'd0,  4'd0, 4'd0,  4'd0},
    '{4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0,  4'd0,  4'd3, 4'd0,  4'd0},
    '{4'd0, 4'd0, KW_ACC, 4'd0, 4'd0,  4'd0, 4'd0, 4'd0,  4'd0,  4'd0, 4'd0,  4'd0},
    '{4'd0, KW_ACC, 4'd0, 4'd0, 4'd0,  4'd0, 4'd0, 4'd0,  4'd0,  4'd0, 4'd0,  4'd0},
    '{4'd0, 4'd0, 4'd0,  KW_ACC, 4'd0, 4'd0, 4'd0, 4'd0,  4'd0,  4'd0, 4'd0,  4'd0},
    '{4'd0, 4'd0, 4'd7,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0,  4'd0,  4'd0, 4'd0,  4'd0},
    '{4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0,  4'd0,  4'd0, 4'd8,  4'd0},
    '{4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0,  4'd0,  4'd0, 4'd0,  4'd9},
    '{4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd0, 4'd0,  4'd10, 4'd0, 4'd0,  4'd0},
    '{4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd0, KW_ACC, 4'd0, 4'd0, 4'd0,  4'd0},
    '{4'd0, 4'd0, 4'd0,  4'd0,  4'd12, 4'd0, 4'd0, 4'd0,  4'd0,  4'd0, 4'd0,  4'd0},
    '{4'd0, 4'd0, 4'd13, 4'd0,  4'd0,  4'd0, 4'd0, 4'd0,  4'd0,  4'd0, 4'd0,  4'd0},
    '{4'd0, 4'd0, 4'd0,  4'd0,  4'd0,  4'd0, 4'd0, KW_ACC, 4'd0, 4'd0, 4'd0,  4'd0}
  };

  // Letters consumed to reach each state.
  localparam logic [2:0] KW_DEPTH [KW_STATES] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd2, 3'd1, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd1, 3'd2, 3'd3
  };

  // Keyword code of a state once it is completed; none if it cannot complete.
  localparam logic [2:0] KW_CODE [KW_STATES] = '{
    3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0, 3'd4, 3'd0, 3'd0, 3'd5
  };

  // Class of one character code; codes of 128 and above are errors.
  function automatic logic [2:0] classify(input logic [7:0] c);
    logic [2:0] cls;
    cls = CLS_OTHER;
    if (c == 8'd9 || c == 8'd10 || c == 8'd13 || c == 8'd32) begin
      cls = CLS_WS;
    end else if (c == 8'h28 || c == 8'h29 || c == 8'h2b || c == 8'h3b || c == 8'h3d) begin
      cls = CLS_SYM;
    end else if ((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a)) begin
      cls = CLS_ALPHA;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      cls = CLS_DIGIT;
    end
    return cls;
  endfunction

  // Column of a letter in the automaton table; any other letter maps to column zero.
  function automatic logic [3:0] letter_column(input logic [7:0] c);
    logic [3:0] col;
    unique case (c)
      8'h64:   col = 4'd1;  // d
      8'h65:   col = 4'd2;  // e
      8'h66:   col = 4'd3;  // f
      8'h68:   col = 4'd4;  // h
      8'h69:   col = 4'd5;  // i
      8'h6c:   col = 4'd6;  // l
      8'h6e:   col = 4'd7;  // n
      8'h72:   col = 4'd8;  // r
      8'h73:   col = 4'd9;  // s
      8'h74:   col = 4'd10; // t
      8'h75:   col = 4'd11; // u
      default: col = 4'd0;
    endcase
    return col;
  endfunction

  // True when the run so far spells a whole keyword.
  function automatic logic kw_accepted(input logic [3:0] ks, input logic [7:0] rl);
    logic acc;
    acc = 1'b0;
    if (ks < 4'(KW_STATES)) begin
      acc = (KW_CODE[ks] != KWC_NONE) && (rl == {5'd0, KW_DEPTH[ks]} + 8'd1);
    end
    return acc;
  endfunction

  // Advance the automaton by one letter; rl is the run length before it.
  function automatic logic [3:0] kw_advance(input logic [3:0] ks, input logic [7:0] rl,
                                            input logic [7:0] c);
    logic [3:0] nx;
    logic [3:0] res;
    nx = KW_DEAD;
    if (ks >= 4'(KW_STATES) || kw_accepted(ks, rl)) begin
      res = KW_DEAD;
    end else begin
      nx = KW_NEXT[ks][letter_column(c)];
      if (nx == KW_ACC) begin
        res = ks;
      end else if (nx == KW_NONE) begin
        res = KW_DEAD;
      end else begin
        res = nx;
      end
    end
    return res;
  endfunction

  // Token given when a pending run is closed.
  function automatic result_t close_token(input logic [1:0] mode, input logic [3:0] ks,
                                          input logic [7:0] rl);
    result_t r;
    r.len  = rl;
    r.last = 1'b0;
    r.kw   = KWC_NONE;
    if (mode == MODE_NUM) begin
      r.kind = KIND_NUM;
    end else if (kw_accepted(ks, rl)) begin
      r.kind = KIND_KW;
      r.kw   = KW_CODE[ks];
    end else begin
      r.kind = KIND_ID;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/token_scanner_keyword_dfa.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// token_scanner_keyword_dfa
// Streaming lexical scanner: numbers, identifiers, keywords, symbols and
// whitespace, with an error stop on any unknown character.
// ---------------------------------------------------------------------------
//
//  Channel  | Dir | Word contents (lowest bit up)
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | tdata: char_code[7:0]; tlast: end_of_text
//  m_axis   | out | tdata: token_kind[2:0], token_length[10:3],
//           |     |        keyword_code[13:11], zero[15:14]; tlast: last_of_run
//
//  One character word is taken per clock. Each word is scanned in the cycle it
//  is accepted and its zero, one or two token words go into a four-entry
//  result queue; one token word leaves per clock while the receiver is ready.
//  Input is taken while the queue has two free entries, so two tokens per
//  character run at the output rate of one token per clock. Synchronous reset
//  empties the queue and returns the scanner to idle, clearing the error stop.
//
module token_scanner_keyword_dfa (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // char_code[7:0]
  input  wire logic        s_axis_tlast,  // end_of_text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // token_kind, token_length, keyword_code, zero
  output logic             m_axis_tlast   // last_of_run
);
  import tskd_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTRW  = $clog2(QDEPTH);
  localparam int QCNTW  = $clog2(QDEPTH + 1);

  // Scanner state.
  logic [1:0] scan_mode, scan_mode_next;
  logic [3:0] keyword_state, keyword_state_next;
  logic [7:0] run_length, run_length_next;

  // Result queue.
  result_t            queue [QDEPTH];
  logic [QPTRW-1:0]   wr_ptr, rd_ptr;
  logic [QCNTW-1:0]   count;

  logic       in_accept, out_accept;
  logic [2:0] cls;
  logic       cont;
  result_t    res0, res1, tok;
  logic [1:0] nres;

  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign out_accept = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (count <= QCNTW'(QDEPTH - 2));

  // Scan one character: work out the next state and the tokens it gives.
  always_comb begin
    cls  = classify(s_axis_tdata);
    cont = (scan_mode == MODE_NUM && cls == CLS_DIGIT) ||
           (scan_mode == MODE_WORD && cls == CLS_ALPHA);
    scan_mode_next     = scan_mode;
    keyword_state_next = keyword_state;
    run_length_next    = run_length;
    res0 = '0;
    res1 = '0;
    nres = 2'd0;
    tok  = '0;

    if (scan_mode != MODE_HALT) begin
      if (cont) begin
        if (scan_mode == MODE_WORD) begin
          keyword_state_next = kw_advance(keyword_state, run_length, s_axis_tdata);
        end
        if (run_length < 8'(LEN_CAP)) begin
          run_length_next = run_length + 8'd1;
        end
      end else begin
        // Close the pending run first.
        if (scan_mode == MODE_NUM || scan_mode == MODE_WORD) begin
          res0 = close_token(scan_mode, keyword_state, run_length);
          nres = 2'd1;
        end
        scan_mode_next     = MODE_IDLE;
        keyword_state_next = KW_START;
        run_length_next    = 8'd0;
        tok.len  = 8'd1;
        tok.kw   = KWC_NONE;
        tok.last = 1'b0;
        unique case (cls)
          CLS_WS: begin
            tok.kind = KIND_WS;
          end
          CLS_SYM: begin
            tok.kind = KIND_SYM;
          end
          CLS_ALPHA: begin
            scan_mode_next     = MODE_WORD;
            keyword_state_next = kw_advance(KW_START, 8'd0, s_axis_tdata);
            run_length_next    = 8'd1;
          end
          CLS_DIGIT: begin
            scan_mode_next  = MODE_NUM;
            run_length_next = 8'd1;
          end
          default: begin
            tok.kind       = KIND_ERR;
            scan_mode_next = MODE_HALT;
          end
        endcase
        if (cls == CLS_WS || cls == CLS_SYM || cls == CLS_OTHER) begin
          if (nres == 2'd0) begin
            res0 = tok;
          end else begin
            res1 = tok;
          end
          nres = nres + 2'd1;
        end
      end

      // End of text closes whatever run is still open.
      if (s_axis_tlast && (scan_mode_next == MODE_NUM || scan_mode_next == MODE_WORD)) begin
        tok = close_token(scan_mode_next, keyword_state_next, run_length_next);
        if (nres == 2'd0) begin
          res0 = tok;
        end else begin
          res1 = tok;
        end
        nres = nres + 2'd1;
        scan_mode_next     = MODE_IDLE;
        keyword_state_next = KW_START;
        run_length_next    = 8'd0;
      end

      // Mark the final token of this character.
      if (nres == 2'd1) begin
        res0.last = 1'b1;
      end else if (nres == 2'd2) begin
        res1.last = 1'b1;
      end
    end
  end

  // Scanner state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= MODE_IDLE;
      keyword_state <= KW_START;
      run_length    <= 8'd0;
    end else if (in_accept) begin
      scan_mode     <= scan_mode_next;
      keyword_state <= keyword_state_next;
      run_length    <= run_length_next;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_accept) begin
        wr_ptr <= wr_ptr + QPTRW'(nres);
      end
      if (out_accept) begin
        rd_ptr <= rd_ptr + QPTRW'(1);
      end
      count <= count + QCNTW'(in_accept ? nres : 2'd0) - QCNTW'(out_accept);
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (in_accept && nres != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (in_accept && nres == 2'd2) begin
      queue[wr_ptr + QPTRW'(1)] <= res1;
    end
  end

  // Output word.
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = {2'b00, queue[rd_ptr].kw, queue[rd_ptr].len, queue[rd_ptr].kind};
  assign m_axis_tlast  = queue[rd_ptr].last;

  // Checks.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNTW'(QDEPTH))
    else $error("result queue overfilled");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    scan_mode == MODE_HALT |=> scan_mode == MODE_HALT)
    else $error("scanner left the error stop without reset");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (scan_mode == MODE_HALT && in_accept) |-> nres == 2'd0)
    else $error("tokens produced while stopped");

  a_kw_shape: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && queue[rd_ptr].kind == KIND_KW) |->
      (queue[rd_ptr].kw != KWC_NONE && queue[rd_ptr].len >= 8'd2 &&
       queue[rd_ptr].len <= 8'd6))
    else $error("keyword token with bad code or length");

endmodule
`default_nettype wire

@@ tb/sv/token_scanner_keyword_dfa_checker.sv @@
// ---------------------------------------------------------------------------
// token_scanner_keyword_dfa_checker
// Watches both streams of the scanner, works out the token words that each
// accepted character word should give, and compares every token word that
// leaves the block, field by field, with the oldest one still due.
// ---------------------------------------------------------------------------
module token_scanner_keyword_dfa_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // char_code[7:0]
  input  logic        s_axis_tlast,  // end_of_text
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,  // token_kind, token_length, keyword_code, zero
  input  logic        m_axis_tlast,  // last_of_run
  output int          mismatches,
  output int          outstanding
);
  import tskd_pkg::*;

  // Keyword codes, in the order of the word list below.
  localparam logic [2:0] KWC_ELSE   = 3'd1;
  localparam logic [2:0] KWC_END    = 3'd2;
  localparam logic [2:0] KWC_IF     = 3'd3;
  localparam logic [2:0] KWC_RETURN = 3'd4;
  localparam logic [2:0] KWC_THEN   = 3'd5;
  localparam logic [2:0] WORD_CODES [5] = '{KWC_ELSE, KWC_END, KWC_IF, KWC_RETURN, KWC_THEN};

  // The longest keyword has six letters; seven seen means the run is too long.
  localparam int HEAD_LEN = 6;

  string keywords [5] = '{"else", "end", "if", "return", "then"};

  // Predicted scanner state.
  logic [1:0] mode;
  logic [7:0] run_len;
  logic [7:0] head_text [HEAD_LEN];
  int         letters_seen;

  result_t tokens_due [$];
  int      step_tokens;

  task automatic report(input string what);
    $display("%0t ns-less step: %s", $time, what);
    mismatches++;
  endtask

  task automatic push_token(input logic [2:0] kind, input logic [7:0] len,
                            input logic [2:0] kw);
    result_t t;
    t.kind = kind;
    t.len  = len;
    t.kw   = kw;
    t.last = 1'b0;
    tokens_due.insert(tokens_due.size(), t);
    step_tokens++;
  endtask

  function automatic logic [2:0] char_class(input logic [7:0] c);
    if (c[7]) return CLS_OTHER;
    if (c == 8'd9 || c == 8'd10 || c == 8'd13 || c == 8'd32) return CLS_WS;
    if (c == "(" || c == ")" || c == "+" || c == ";" || c == "=") return CLS_SYM;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return CLS_ALPHA;
    if (c >= "0" && c <= "9") return CLS_DIGIT;
    return CLS_OTHER;
  endfunction

  // A run is a keyword only when the whole run spells one of the lowercase words.
  function automatic logic [2:0] spelled_keyword();
    logic same;
    for (int k = 0; k < 5; k++) begin
      if (letters_seen == keywords[k].len()) begin
        same = 1'b1;
        for (int i = 0; i < letters_seen; i++) begin
          if (head_text[i] != keywords[k][i]) same = 1'b0;
        end
        if (same) return WORD_CODES[k];
      end
    end
    return KWC_NONE;
  endfunction

  task automatic close_pending();
    logic [2:0] code;
    if (mode == MODE_NUM) begin
      push_token(KIND_NUM, run_len, KWC_NONE);
    end else if (mode == MODE_WORD) begin
      code = spelled_keyword();
      if (code != KWC_NONE) begin
        push_token(KIND_KW, run_len, code);
      end else begin
        push_token(KIND_ID, run_len, KWC_NONE);
      end
    end
    mode         = MODE_IDLE;
    run_len      = '0;
    letters_seen = 0;
  endtask

  // Lengths stop at the cap; the letter record keeps only the head of the run.
  task automatic extend_run(input logic [7:0] c);
    if (mode == MODE_WORD) begin
      if (letters_seen < HEAD_LEN) head_text[letters_seen] = c;
      if (letters_seen <= HEAD_LEN) letters_seen++;
    end
    if (run_len < 8'(LEN_CAP)) run_len++;
  endtask

  // Works out the token words for one character word and queues them.
  task automatic tokenise_char(input logic [7:0] c, input logic eot);
    logic [2:0] cls;
    cls = char_class(c);
    step_tokens = 0;
    if (mode == MODE_HALT) return;
    if ((mode == MODE_NUM && cls == CLS_DIGIT) || (mode == MODE_WORD && cls == CLS_ALPHA)) begin
      extend_run(c);
    end else begin
      close_pending();
      case (cls)
        CLS_WS: begin
          push_token(KIND_WS, 8'd1, KWC_NONE);
        end
        CLS_SYM: begin
          push_token(KIND_SYM, 8'd1, KWC_NONE);
        end
        CLS_ALPHA: begin
          mode = MODE_WORD;
          extend_run(c);
        end
        CLS_DIGIT: begin
          mode = MODE_NUM;
          extend_run(c);
        end
        default: begin
          push_token(KIND_ERR, 8'd1, KWC_NONE);
          mode = MODE_HALT;
        end
      endcase
    end
    if (eot && (mode == MODE_NUM || mode == MODE_WORD)) close_pending();
    if (step_tokens > 0) begin
      tokens_due[tokens_due.size() - 1].last = 1'b1;
    end
  endtask

  // Output words are compared before the input word of the same edge is scanned.
  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      mode         = MODE_IDLE;
      run_len      = '0;
      letters_seen = 0;
      tokens_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (tokens_due.size() == 0) begin
          report($sformatf("token word 0x%04h with none due", m_axis_tdata));
        end else begin
          want = tokens_due.pop_front();
          if (m_axis_tdata[2:0] != want.kind)
            report($sformatf("token kind %0d, due %0d", m_axis_tdata[2:0], want.kind));
          if (m_axis_tdata[10:3] != want.len)
            report($sformatf("token length %0d, due %0d", m_axis_tdata[10:3], want.len));
          if (m_axis_tdata[13:11] != want.kw)
            report($sformatf("keyword code %0d, due %0d", m_axis_tdata[13:11], want.kw));
          if (m_axis_tdata[15:14] != 2'b00)
            report($sformatf("padding bits %0d, due 0", m_axis_tdata[15:14]));
          if (m_axis_tlast != want.last)
            report($sformatf("last of run %0d, due %0d", m_axis_tlast, want.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) tokenise_char(s_axis_tdata, s_axis_tlast);
    end
    outstanding <= tokens_due.size();
  end

endmodule

@@ tb/sv/token_scanner_keyword_dfa_tb.sv @@
// ---------------------------------------------------------------------------
// token_scanner_keyword_dfa_tb
// Drives character words into the scanner: a short directed text, a long
// saturating run, then mostly well-formed random tokens with some noise, and
// finally an error character followed by words that must be ignored. Both
// streams idle at random; the checker beside the block does all comparing.
// ---------------------------------------------------------------------------
module token_scanner_keyword_dfa_tb;

  localparam int LIMIT_CYCLES = 500000;
  localparam int HOLD_CYCLES  = 80;
  localparam int RANDOM_CHARS = 140;

  localparam logic [7:0] SPACE_CODES  [4] = '{8'd9, 8'd10, 8'd13, 8'd32};
  localparam logic [7:0] SYMBOL_CODES [5] = '{8'h28, 8'h29, 8'h2b, 8'h3b, 8'h3d};
  localparam logic [7:0] ERROR_CODES  [5] = '{8'h00, 8'h21, 8'h7f, 8'h80, 8'hff};

  string keywords [5] = '{"else", "end", "if", "return", "then"};

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  int mismatch_count;
  int pending_tokens;
  int chars_sent;
  int cycle_count;
  bit steady;
  bit hold_off_req;

  always #2 clk = ~clk;

  token_scanner_keyword_dfa dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  token_scanner_keyword_dfa_checker token_watch (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatch_count),
    .outstanding   (pending_tokens)
  );

  // Mostly no pause, sometimes a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_lower();
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) == 0) ? rand_lower() : 8'h41 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  // Any character that the scanner takes without an error stop.
  function automatic logic [7:0] rand_valid_char();
    case ($urandom_range(0, 3))
      0:       return SPACE_CODES[$urandom_range(0, 3)];
      1:       return SYMBOL_CODES[$urandom_range(0, 4)];
      2:       return rand_letter();
      default: return rand_digit();
    endcase
  endfunction

  // Offers one character word and holds it until it is taken.
  task automatic send_char(input logic [7:0] c, input logic eot);
    int gap;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eot;
    do @(posedge clk); while (!s_axis_tready);
    chars_sent++;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      s_axis_tlast  <= 1'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // End of text falls on about one character in twenty.
  task automatic feed(input logic [7:0] c);
    send_char(c, $urandom_range(0, 19) == 0);
  endtask

  task automatic send_text(input string s, input logic eot_last);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], eot_last && (i == s.len() - 1));
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_tokens != 0);
  endtask

  // One random token: keywords, near misses, identifiers, numbers, symbols,
  // whitespace, and a little single-character noise.
  task automatic send_random_token();
    int    r;
    int    n;
    int    pos;
    string w;
    r = $urandom_range(0, 99);
    w = keywords[$urandom_range(0, 4)];
    if (r < 22) begin
      for (int i = 0; i < w.len(); i++) feed(w[i]);
    end else if (r < 34) begin
      case ($urandom_range(0, 2))
        0: begin
          n = $urandom_range(1, w.len() - 1);
          for (int i = 0; i < n; i++) feed(w[i]);
        end
        1: begin
          for (int i = 0; i < w.len(); i++) feed(w[i]);
          feed(rand_lower());
        end
        default: begin
          pos = $urandom_range(0, w.len() - 1);
          for (int i = 0; i < w.len(); i++) feed((i == pos) ? w[i] - 8'd32 : w[i]);
        end
      endcase
    end else if (r < 48) begin
      repeat ($urandom_range(1, 8)) feed(rand_letter());
    end else if (r < 58) begin
      repeat ($urandom_range(1, 6)) feed(rand_digit());
    end else if (r < 72) begin
      feed(SYMBOL_CODES[$urandom_range(0, 4)]);
    end else if (r < 88) begin
      feed(SPACE_CODES[$urandom_range(0, 3)]);
    end else begin
      feed(rand_valid_char());
    end
  endtask

  // Receiver: random ready and stall stretches, a long hold-off on request,
  // and a steady ready while the stimulus asks for a stretch without idling.
  initial begin : sink
    int run;
    int gap;
    forever begin
      if (hold_off_req) begin
        @(negedge clk);
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (steady) begin
        @(negedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        run = $urandom_range(1, 8);
        @(negedge clk);
        m_axis_tready <= 1'b1;
        repeat (run - 1) @(negedge clk);
        gap = idle_len();
        if (gap > 0) begin
          @(negedge clk);
          m_axis_tready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("token_scanner_keyword_dfa: mismatch");
    $finish;
  end

  initial begin : stimulus
    int random_end;
    int random_start;
    bit did_hold;
    bit did_drain;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed text: keywords else, end and if, uppercase, letters after a keyword,
    // class changes between digits and letters, each symbol, end of text on a word.
    send_text("else\t", 1'b0);
    send_text("end(", 1'b0);
    send_text("thenx+", 1'b0);
    send_text("If=", 1'b0);
    send_text("09z5\n", 1'b0);
    send_char(8'd13, 1'b0);
    send_text(";)", 1'b0);
    send_text("if", 1'b1);
    wait_drained();

    // A letter run longer than the length cap, starting with a keyword.
    send_char(8'd32, 1'b0);
    send_text("else", 1'b0);
    repeat (252) send_char(rand_lower(), 1'b0);
    send_char(rand_lower(), 1'b1);

    // Random tokens, with a long receiver hold-off, a full drain and a
    // stretch without any idling on either side.
    random_start = chars_sent;
    random_end   = chars_sent + RANDOM_CHARS;
    did_hold     = 1'b0;
    did_drain    = 1'b0;
    while (chars_sent < random_end) begin
      if (!did_hold && chars_sent >= random_start + 20) begin
        steady       = 1'b1;
        hold_off_req = 1'b1;
        repeat (40) feed(rand_valid_char());
        steady   = 1'b0;
        did_hold = 1'b1;
      end
      if (!did_drain && chars_sent >= random_start + 100) begin
        wait_drained();
        did_drain = 1'b1;
      end
      steady = (chars_sent >= random_start + 60) && (chars_sent < random_start + 90);
      send_random_token();
    end
    steady = 1'b0;

    // Error stop with a word pending, then words that must all be ignored.
    send_text("ab", 1'b0);
    send_char(ERROR_CODES[$urandom_range(0, 4)], 1'($urandom));
    repeat (20) send_char(8'($urandom_range(0, 255)), 1'($urandom));

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("token_scanner_keyword_dfa: match");
    end else begin
      $display("token_scanner_keyword_dfa: mismatch");
    end
    $finish;
  end

endmodule
